// File: design/tass_pkg.sv
`default_nettype none

package tass_pkg;

   localparam int ROWS    = 8;
   localparam int COLUMNS = 8;

   localparam int CNT_W     = 3;
   localparam int LIMIT_W   = 20;
   localparam int SAMPLE_W  = 12;
   localparam int EVENT_W   = 3;
   localparam int PHASE_W   = 3;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 20;

   localparam logic [CNT_W-1:0]    ROW_LAST      = CNT_W'(ROWS - 1);
   localparam logic [CNT_W-1:0]    COLUMN_LAST   = CNT_W'(COLUMNS - 1);
   localparam logic [LIMIT_W-1:0]  TIMEOUT_RESET = LIMIT_W'(100000);
   localparam logic [SAMPLE_W-1:0] SAMPLE_MAX    = '1;

   localparam logic [CSR_IDX_W-1:0] REG_TIMEOUT_LIMIT = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_SAMPLE_OFFSET = CSR_IDX_W'(1);

   localparam logic [PHASE_W-1:0] PH_FRAME_LOW   = 3'd0;
   localparam logic [PHASE_W-1:0] PH_FRAME_HIGH  = 3'd1;
   localparam logic [PHASE_W-1:0] PH_CONFIRM     = 3'd2;
   localparam logic [PHASE_W-1:0] PH_CLOCK_START = 3'd3;
   localparam logic [PHASE_W-1:0] PH_CELL_LOW    = 3'd4;
   localparam logic [PHASE_W-1:0] PH_CELL_HIGH   = 3'd5;

   localparam logic [EVENT_W-1:0] EV_SAMPLE           = 3'd0;
   localparam logic [EVENT_W-1:0] EV_FRAME_STUCK_HIGH = 3'd1;
   localparam logic [EVENT_W-1:0] EV_FRAME_STUCK_LOW  = 3'd2;
   localparam logic [EVENT_W-1:0] EV_CLOCK_STUCK_HIGH = 3'd3;
   localparam logic [EVENT_W-1:0] EV_CLOCK_STUCK_LOW  = 3'd4;

   typedef struct packed {
      logic [PHASE_W-1:0] phase;
      logic [LIMIT_W-1:0] wait_count;
      logic [CNT_W-1:0]   row;
      logic [CNT_W-1:0]   column;
   } state_type;

   typedef struct packed {
      logic [LIMIT_W-1:0]         timeout_limit;
      logic signed [SAMPLE_W-1:0] sample_offset;
   } cfg_type;

   typedef struct packed {
      logic [EVENT_W-1:0]  event_res;
      logic [CNT_W-1:0]    row;
      logic [CNT_W-1:0]    column;
      logic [SAMPLE_W-1:0] value;
      logic                last_cell;
   } result_type;

endpackage

`default_nettype wire

// File: design/tass_if.sv
`default_nettype none

interface tass_req_if import tass_pkg::*;;
   logic                valid;
   logic                ready;
   logic                frame_sync;
   logic                cell_clock;
   logic [SAMPLE_W-1:0] adc_sample;

   modport source (output valid, frame_sync, cell_clock, adc_sample, input ready);
   modport sink   (input valid, frame_sync, cell_clock, adc_sample, output ready);
endinterface

interface tass_rsp_if import tass_pkg::*;;
   logic                valid;
   logic                ready;
   logic [EVENT_W-1:0]  event_res;
   logic [CNT_W-1:0]    row;
   logic [CNT_W-1:0]    column;
   logic [SAMPLE_W-1:0] value;
   logic                last_cell;

   modport source (output valid, event_res, row, column, value, last_cell, input ready);
   modport sink   (input valid, event_res, row, column, value, last_cell, output ready);
endinterface

interface tass_csr_if import tass_pkg::*;;
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [CSR_DAT_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: design/tass_step.sv
`default_nettype none

module tass_step import tass_pkg::*; (
   input  state_type           cur,
   input  cfg_type             cfg,
   input  logic                frame_sync,
   input  logic                cell_clock,
   input  logic [SAMPLE_W-1:0] adc_sample,
   output state_type           nxt,
   output logic                emit,
   output result_type          res
);

   logic                       wait_hit;
   logic [LIMIT_W-1:0]         wait_inc;
   logic signed [SAMPLE_W+1:0] sum;
   logic [SAMPLE_W-1:0]        clamped;
   logic                       row_end;
   logic                       last;

   assign wait_hit = cur.wait_count >= cfg.timeout_limit;
   assign wait_inc = cur.wait_count + LIMIT_W'(1);
   assign sum      = $signed({2'b00, adc_sample})
                   + $signed({{2{cfg.sample_offset[SAMPLE_W-1]}}, cfg.sample_offset});
   assign row_end  = cur.row == ROW_LAST;
   assign last     = row_end && (cur.column == COLUMN_LAST);

   always_comb begin
      if (sum[SAMPLE_W+1]) begin
         clamped = '0;
      end else if (sum[SAMPLE_W]) begin
         clamped = SAMPLE_MAX;
      end else begin
         clamped = sum[SAMPLE_W-1:0];
      end
   end

   always_comb begin
      logic                 unmet;
      logic [EVENT_W-1:0]   err_code;
      logic [PHASE_W-1:0]   met_phase;
      unmet     = 1'b0;
      err_code  = EV_FRAME_STUCK_HIGH;
      met_phase = PH_FRAME_LOW;
      nxt       = cur;
      emit      = 1'b0;
      res       = '0;
      unique case (cur.phase)
         PH_FRAME_HIGH: begin
            unmet     = !frame_sync;
            err_code  = EV_FRAME_STUCK_LOW;
            met_phase = PH_CONFIRM;
         end
         PH_CONFIRM: begin
            nxt.wait_count = '0;
            if (frame_sync) begin
               nxt.phase = PH_CLOCK_START;
            end else begin
               nxt = '0;
            end
         end
         PH_CLOCK_START: begin
            unmet     = !cell_clock;
            err_code  = EV_CLOCK_STUCK_LOW;
            met_phase = PH_CELL_LOW;
         end
         PH_CELL_LOW: begin
            unmet     = cell_clock;
            err_code  = EV_CLOCK_STUCK_HIGH;
            met_phase = PH_CELL_HIGH;
         end
         PH_CELL_HIGH: begin
            unmet     = !cell_clock;
            err_code  = EV_CLOCK_STUCK_LOW;
            met_phase = PH_CELL_LOW;
         end
         default: begin
            unmet     = frame_sync;
            err_code  = EV_FRAME_STUCK_HIGH;
            met_phase = PH_FRAME_HIGH;
         end
      endcase

      if (cur.phase != PH_CONFIRM) begin
         if (unmet) begin
            nxt.phase = (cur.phase > PH_CELL_HIGH) ? PH_FRAME_LOW : cur.phase;
            if (wait_hit) begin
               nxt           = '0;
               emit          = 1'b1;
               res.event_res = err_code;
            end else begin
               nxt.wait_count = wait_inc;
            end
         end else begin
            nxt.phase      = met_phase;
            nxt.wait_count = '0;
            if (cur.phase == PH_CELL_HIGH) begin
               emit          = 1'b1;
               res.event_res = EV_SAMPLE;
               res.row       = cur.row;
               res.column    = cur.column;
               res.value     = clamped;
               res.last_cell = last;
               if (last) begin
                  nxt = '0;
               end else if (row_end) begin
                  nxt.row    = '0;
                  nxt.column = cur.column + CNT_W'(1);
               end else begin
                  nxt.row = cur.row + CNT_W'(1);
               end
            end
         end
      end
   end

endmodule

`default_nettype wire

// File: design/tactile_array_scan_sequencer_core.sv
`default_nettype none

// Tactile array scan sequencer. Takes one word per clock cycle (frame sync
// level, scan clock level, converter sample), finds a confirmed frame start,
// then samples the 8x8 cells on rising scan clock edges, rows inner, columns
// outer, with the last cell flagged; every level wait times out after
// timeout_limit unmet words with a stuck event. Each word's result, if any,
// lands in the output register in the cycle after acceptance. The sequencer
// state is updated per word, so a new word is accepted every cycle; the input
// stalls only while the output register holds a result the sink has not taken.
// Configuration writes are always accepted and take effect on the next word.

module tactile_array_scan_sequencer_core import tass_pkg::*; (
   input  wire logic   clock,
   input  wire logic   reset,
   tass_req_if.sink    req_bus,
   tass_rsp_if.source  rsp_bus,
   tass_csr_if.sink    csr_bus
);

   state_type  state_ff;
   state_type  state_in;
   cfg_type    cfg_ff;
   result_type rsp_ff;
   result_type step_res;
   logic       rsp_valid_ff;
   logic       step_emit;
   logic       req_take;

   assign req_bus.ready = !rsp_valid_ff || rsp_bus.ready;
   assign req_take      = req_bus.valid && req_bus.ready;
   assign csr_bus.ready = 1'b1;

   tass_step u_step (
      .cur        (state_ff),
      .cfg        (cfg_ff),
      .frame_sync (req_bus.frame_sync),
      .cell_clock (req_bus.cell_clock),
      .adc_sample (req_bus.adc_sample),
      .nxt        (state_in),
      .emit       (step_emit),
      .res        (step_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (req_take) begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.timeout_limit <= TIMEOUT_RESET;
         cfg_ff.sample_offset <= '0;
      end else if (csr_bus.valid) begin
         case (csr_bus.index)
            REG_TIMEOUT_LIMIT: cfg_ff.timeout_limit <= csr_bus.data;
            REG_SAMPLE_OFFSET: cfg_ff.sample_offset <= csr_bus.data[SAMPLE_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_take && step_emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take && step_emit) begin
         rsp_ff <= step_res;
      end
   end

   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.event_res = rsp_ff.event_res;
   assign rsp_bus.row       = rsp_ff.row;
   assign rsp_bus.column    = rsp_ff.column;
   assign rsp_bus.value     = rsp_ff.value;
   assign rsp_bus.last_cell = rsp_ff.last_cell;

`ifndef NO_ASSERTIONS
   a_error_restarts: assert property (@(posedge clock) disable iff (reset)
      (req_take && step_emit && step_res.event_res != EV_SAMPLE)
      |=> (state_ff == '0))
      else $error("stuck event did not return to frame search");

   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      (req_take && step_emit && step_res.last_cell)
      |=> (state_ff.row == '0 && state_ff.column == '0
           && state_ff.phase == PH_FRAME_LOW))
      else $error("last cell did not end the frame");

   a_stall_only_full: assert property (@(posedge clock) disable iff (reset)
      !req_bus.ready |-> rsp_valid_ff)
      else $error("input stalled with empty output register");

   a_last_is_corner: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.last_cell)
      |-> (rsp_ff.row == ROW_LAST && rsp_ff.column == COLUMN_LAST
           && rsp_ff.event_res == EV_SAMPLE))
      else $error("last cell flag on wrong cell");
`endif

endmodule

`default_nettype wire

// File: tb/tactile_array_scan_sequencer_core_tb.sv
module tactile_array_scan_sequencer_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import tass_pkg::*;

   localparam int WATCHDOG_CYCLES = 3000;
   localparam int HOLD_CYCLES     = 300;
   localparam int SETTLE_CYCLES   = 4;
   localparam int REPORT_LINES    = 40;

   localparam logic [CSR_IDX_W-1:0] REG_SPARE_A = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] REG_SPARE_B = CSR_IDX_W'(3);

   typedef enum logic [1:0] {RX_OPEN, RX_RANDOM, RX_SPARSE} rx_mode_type;

   typedef struct packed {
      logic                fs;
      logic                sc;
      logic [SAMPLE_W-1:0] adc;
   } scan_word_type;

   logic clock;
   logic reset;

   tass_req_if req_bus ();
   tass_rsp_if rsp_bus ();
   tass_csr_if csr_bus ();

   tactile_array_scan_sequencer_core u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   scan_word_type word_queue[$];
   result_type    expected_events[$];

   bit req_fire = 1'b0;
   bit csr_fire = 1'b0;
   bit pressure_armed = 1'b0;
   bit pressure_done = 1'b0;
   int words_queued = 0;
   int mismatches = 0;
   int quiet_cycles = 0;
   int burst_left = 0;
   int gap_left = 0;
   int hold_left = 0;
   int mode_left = 0;
   rx_mode_type rx_mode = RX_OPEN;

   // sequencer prediction state
   logic [PHASE_W-1:0]         sq_phase = PH_FRAME_LOW;
   logic [LIMIT_W-1:0]         sq_wait = '0;
   logic [CNT_W-1:0]           sq_row = '0;
   logic [CNT_W-1:0]           sq_col = '0;
   logic [LIMIT_W-1:0]         cfg_limit = TIMEOUT_RESET;
   logic signed [SAMPLE_W-1:0] cfg_offset = '0;

   initial begin
      clock = 1'b0;
   end

   always #5 clock = ~clock;

   function automatic bit coin();
      return 1'($urandom_range(0, 1));
   endfunction

   function automatic void restart_search();
      sq_phase = PH_FRAME_LOW;
      sq_wait  = '0;
      sq_row   = '0;
      sq_col   = '0;
   endfunction

   function automatic void enter_phase(input logic [PHASE_W-1:0] next);
      sq_phase = next;
      sq_wait  = '0;
   endfunction

   function automatic bit wait_expired();
      if (sq_wait >= cfg_limit) return 1'b1;
      sq_wait = sq_wait + 1'b1;
      return 1'b0;
   endfunction

   function automatic void apply_register(input logic [CSR_IDX_W-1:0] idx,
                                          input logic [CSR_DAT_W-1:0] wdata);
      if (idx == REG_TIMEOUT_LIMIT) begin
         cfg_limit = wdata[LIMIT_W-1:0];
      end else if (idx == REG_SAMPLE_OFFSET) begin
         cfg_offset = wdata[SAMPLE_W-1:0];
      end
   endfunction

   function automatic bit scan_tick(input scan_word_type w, output result_type res);
      int level;
      bit fired;
      res = '0;
      fired = 1'b0;
      case (sq_phase)
         PH_FRAME_HIGH: begin
            if (w.fs) begin
               enter_phase(PH_CONFIRM);
            end else if (wait_expired()) begin
               res.event_res = EV_FRAME_STUCK_LOW;
               fired = 1'b1;
            end
         end
         PH_CONFIRM: begin
            if (w.fs) enter_phase(PH_CLOCK_START);
            else restart_search();
         end
         PH_CLOCK_START: begin
            if (w.sc) begin
               enter_phase(PH_CELL_LOW);
            end else if (wait_expired()) begin
               res.event_res = EV_CLOCK_STUCK_LOW;
               fired = 1'b1;
            end
         end
         PH_CELL_LOW: begin
            if (!w.sc) begin
               enter_phase(PH_CELL_HIGH);
            end else if (wait_expired()) begin
               res.event_res = EV_CLOCK_STUCK_HIGH;
               fired = 1'b1;
            end
         end
         PH_CELL_HIGH: begin
            if (!w.sc) begin
               if (wait_expired()) begin
                  res.event_res = EV_CLOCK_STUCK_LOW;
                  fired = 1'b1;
               end
            end else begin
               level = int'(w.adc) + int'(cfg_offset);
               if (level < 0) level = 0;
               if (level > int'(SAMPLE_MAX)) level = int'(SAMPLE_MAX);
               res.event_res = EV_SAMPLE;
               res.row       = sq_row;
               res.column    = sq_col;
               res.value     = SAMPLE_W'(level);
               res.last_cell = (sq_row == ROW_LAST) && (sq_col == COLUMN_LAST);
               fired = 1'b1;
               if (res.last_cell) begin
                  restart_search();
               end else begin
                  if (sq_row == ROW_LAST) begin
                     sq_row = '0;
                     sq_col = sq_col + 1'b1;
                  end else begin
                     sq_row = sq_row + 1'b1;
                  end
                  enter_phase(PH_CELL_LOW);
               end
            end
         end
         default: begin
            sq_phase = PH_FRAME_LOW;
            if (!w.fs) begin
               enter_phase(PH_FRAME_HIGH);
            end else if (wait_expired()) begin
               res.event_res = EV_FRAME_STUCK_HIGH;
               fired = 1'b1;
            end
         end
      endcase
      if (fired && res.event_res != EV_SAMPLE) restart_search();
      return fired;
   endfunction

   task automatic report_mismatch(input string msg);
      mismatches++;
      if (mismatches <= REPORT_LINES) $display("%0t mismatch: %s", $realtime, msg);
   endtask

   task automatic check_field(input string name, input logic [SAMPLE_W-1:0] got,
                              input logic [SAMPLE_W-1:0] want);
      if (got !== want) report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
   endtask

   task automatic check_event();
      result_type want;
      if (expected_events.size() == 0) begin
         report_mismatch($sformatf("event_res %0d with nothing expected", rsp_bus.event_res));
      end else begin
         want = expected_events.pop_front();
         check_field("event_res", SAMPLE_W'(rsp_bus.event_res), SAMPLE_W'(want.event_res));
         check_field("row", SAMPLE_W'(rsp_bus.row), SAMPLE_W'(want.row));
         check_field("column", SAMPLE_W'(rsp_bus.column), SAMPLE_W'(want.column));
         check_field("value", rsp_bus.value, want.value);
         check_field("last_cell", SAMPLE_W'(rsp_bus.last_cell), SAMPLE_W'(want.last_cell));
      end
   endtask

   always @(posedge clock) begin : watch_channels
      scan_word_type word;
      result_type    want;
      bit req_now;
      bit rsp_now;
      bit csr_now;
      req_now = (req_bus.valid === 1'b1) && (req_bus.ready === 1'b1);
      rsp_now = (rsp_bus.valid === 1'b1) && (rsp_bus.ready === 1'b1);
      csr_now = (csr_bus.valid === 1'b1) && (csr_bus.ready === 1'b1);
      req_fire <= req_now;
      csr_fire <= csr_now;
      if (!reset) begin
         if (csr_now) apply_register(csr_bus.index, csr_bus.data);
         if (rsp_now) check_event();
         if (req_now) begin
            word.fs  = req_bus.frame_sync;
            word.sc  = req_bus.cell_clock;
            word.adc = req_bus.adc_sample;
            if (scan_tick(word, want)) expected_events.push_back(want);
         end
         if (req_now || rsp_now || csr_now) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_CYCLES) begin
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   // hold the word until taken, then advance in bursts with gaps
   always @(negedge clock) begin : drive_words
      scan_word_type word;
      if (!reset && !(req_bus.valid && !req_fire)) begin
         if (gap_left > 0) begin
            gap_left--;
            req_bus.valid <= 1'b0;
         end else if (word_queue.size() > 0) begin
            word = word_queue.pop_front();
            req_bus.valid      <= 1'b1;
            req_bus.frame_sync <= word.fs;
            req_bus.cell_clock <= word.sc;
            req_bus.adc_sample <= word.adc;
            if (burst_left > 0) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(0, 30);
               gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            end
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin : drive_ready
      if (hold_left > 0) begin
         hold_left--;
         rsp_bus.ready <= 1'b0;
      end else if (pressure_armed && !pressure_done) begin
         pressure_done = 1'b1;
         hold_left = HOLD_CYCLES;
         rsp_bus.ready <= 1'b0;
      end else begin
         if (mode_left == 0) begin
            rx_mode   = rx_mode_type'($urandom_range(0, 2));
            mode_left = $urandom_range(8, 60);
         end else begin
            mode_left--;
         end
         case (rx_mode)
            RX_OPEN:   rsp_bus.ready <= 1'b1;
            RX_RANDOM: rsp_bus.ready <= coin();
            default:   rsp_bus.ready <= ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   function automatic logic [SAMPLE_W-1:0] random_sample();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return SAMPLE_MAX;
         default: return SAMPLE_W'($urandom);
      endcase
   endfunction

   function automatic int pick_wait(input int unsigned lim);
      if (lim <= 8 && $urandom_range(0, 149) == 0) return lim + 1;
      return $urandom_range(0, (lim < 2) ? lim : 2);
   endfunction

   task automatic push_word(input bit fs, input bit sc, input logic [SAMPLE_W-1:0] adc);
      scan_word_type word;
      word.fs  = fs;
      word.sc  = sc;
      word.adc = adc;
      word_queue.push_back(word);
      words_queued++;
   endtask

   task automatic queue_frame(input int unsigned lim, input int cells);
      repeat (pick_wait(lim)) push_word(1'b1, coin(), random_sample());
      push_word(1'b0, coin(), random_sample());
      repeat (pick_wait(lim)) push_word(1'b0, coin(), random_sample());
      push_word(1'b1, coin(), random_sample());
      push_word(1'b1, coin(), random_sample());
      repeat (pick_wait(lim)) push_word(coin(), 1'b0, random_sample());
      push_word(coin(), 1'b1, random_sample());
      repeat (cells) begin
         repeat (pick_wait(lim)) push_word(coin(), 1'b1, random_sample());
         push_word(coin(), 1'b0, random_sample());
         repeat (pick_wait(lim)) push_word(coin(), 1'b0, random_sample());
         push_word(coin(), 1'b1, random_sample());
      end
   endtask

   task automatic queue_random(input int budget, input int unsigned lim);
      int target;
      target = words_queued + budget;
      while (words_queued < target) begin
         case ($urandom_range(0, 9))
            0: begin
               repeat ($urandom_range(1, 6)) begin
                  push_word(coin(), coin(), random_sample());
               end
            end
            1: begin
               push_word(1'b0, coin(), random_sample());
               push_word(1'b1, coin(), random_sample());
               push_word(1'b0, coin(), random_sample());
            end
            default: begin
               queue_frame(lim, ($urandom_range(0, 9) < 4) ? ROWS * COLUMNS
                                                          : $urandom_range(1, ROWS * COLUMNS - 1));
            end
         endcase
      end
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [CSR_DAT_W-1:0] wdata);
      @(negedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= wdata;
      do @(negedge clock); while (!csr_fire);
      csr_bus.valid <= 1'b0;
   endtask

   task automatic write_offset(input logic [SAMPLE_W-1:0] offset);
      logic [CSR_DAT_W-1:0] wdata;
      wdata = CSR_DAT_W'($urandom);
      wdata[SAMPLE_W-1:0] = offset;
      write_register(REG_SAMPLE_OFFSET, wdata);
   endtask

   task automatic wait_idle();
      while (word_queue.size() != 0 || req_bus.valid || expected_events.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      reset = 1'b1;
      req_bus.valid      = 1'b0;
      req_bus.frame_sync = 1'b0;
      req_bus.cell_clock = 1'b0;
      req_bus.adc_sample = '0;
      rsp_bus.ready      = 1'b0;
      csr_bus.valid      = 1'b0;
      csr_bus.index      = '0;
      csr_bus.data       = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      write_register(REG_TIMEOUT_LIMIT, CSR_DAT_W'(1));
      write_offset(SAMPLE_W'(2047));
      write_register(REG_SPARE_A, CSR_DAT_W'($urandom));

      // frame stuck high
      push_word(1'b1, 1'b0, '0);
      push_word(1'b1, 1'b1, SAMPLE_MAX);
      // frame stuck low
      push_word(1'b0, 1'b0, '0);
      push_word(1'b0, 1'b1, '0);
      push_word(1'b0, 1'b0, SAMPLE_MAX);
      // glitch on the confirm word
      push_word(1'b0, 1'b0, '0);
      push_word(1'b1, 1'b0, '0);
      push_word(1'b0, 1'b1, '0);
      // scan clock never starts
      push_word(1'b0, 1'b1, '0);
      push_word(1'b1, 1'b1, '0);
      push_word(1'b1, 1'b1, '0);
      push_word(1'b1, 1'b0, SAMPLE_MAX);
      push_word(1'b0, 1'b0, SAMPLE_MAX);
      // scan clock stuck high
      push_word(1'b0, 1'b0, '0);
      push_word(1'b1, 1'b0, '0);
      push_word(1'b1, 1'b0, '0);
      push_word(1'b0, 1'b1, '0);
      push_word(1'b1, 1'b1, '0);
      push_word(1'b0, 1'b1, SAMPLE_MAX);
      // one clamped cell, then scan clock stuck low
      push_word(1'b0, 1'b0, '0);
      push_word(1'b1, 1'b0, '0);
      push_word(1'b1, 1'b0, '0);
      push_word(1'b0, 1'b1, '0);
      push_word(1'b1, 1'b0, '0);
      push_word(1'b0, 1'b1, SAMPLE_MAX);
      push_word(1'b1, 1'b0, '0);
      push_word(1'b0, 1'b0, '0);
      push_word(1'b1, 1'b0, SAMPLE_MAX);
      wait_idle();

      write_offset(SAMPLE_W'(-2048));
      queue_random(60, 1);
      wait_idle();

      write_register(REG_TIMEOUT_LIMIT, CSR_DAT_W'(3));
      write_offset(SAMPLE_W'($urandom));
      write_register(REG_SPARE_B, CSR_DAT_W'($urandom));
      queue_random(60, 3);
      wait_idle();

      write_register(REG_TIMEOUT_LIMIT, {CSR_DAT_W{1'b1}});
      write_offset(SAMPLE_W'(5));
      pressure_armed = 1'b1;
      queue_random(120, {LIMIT_W{1'b1}});
      wait_idle();

      repeat (8) @(posedge clock);
      if (mismatches == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
